// File: hdl/pidc_pkg.sv
// Shared types and constants for the discrete PID controller step block.
package pidc_pkg;

  localparam int GAIN_W  = 24;
  localparam int ERR_W   = 32;
  localparam int SUM_W   = 48;
  localparam int OUT_W   = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN        = 3'd0,
    REG_INTEGRAL_RECIP   = 3'd1,
    REG_INTEGRAL_ENABLE  = 3'd2,
    REG_DERIV_GAIN       = 3'd3,
    REG_SCALE_BEFORE_SUM = 3'd4
  } reg_index_t;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_recip_gain;
    logic              integral_enable;
    logic [GAIN_W-1:0] deriv_gain;
    logic              scale_before_sum;
  } cfg_t;

  typedef struct packed {
    logic                    opcode;
    logic signed [ERR_W-1:0] error_sample;
  } step_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] control_value;
    logic                    saturated;
  } result_item_t;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// File: hdl/pidc_cfg.sv
// Configuration register file for the PID controller step block.
module pidc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidc_pkg::GAIN_W-1:0]     cfg_data,
  output pidc_pkg::cfg_t                  cfg
);
  import pidc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_PROP_GAIN:        cfg.prop_gain           <= cfg_data;
        REG_INTEGRAL_RECIP:   cfg.integral_recip_gain <= cfg_data;
        REG_INTEGRAL_ENABLE:  cfg.integral_enable     <= cfg_data[0];
        REG_DERIV_GAIN:       cfg.deriv_gain          <= cfg_data;
        REG_SCALE_BEFORE_SUM: cfg.scale_before_sum    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/pid_controller_step.sv
// A step transaction passes through pipeline stages v1 to v5 and then the result register.
// Throughput: one transaction per cycle while result_stall does not hold the pipeline;
// the integral sum and previous error are updated in registered feedback loops,
// and all gain products are pipelined. A clear transaction takes a pipeline slot but
// produces no result. Reset (synchronous, active high) clears the configuration
// registers, the integral sum and the previous error, and empties the pipeline.
module pid_controller_step (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step_valid,
  output logic                            step_stall,
  input  pidc_pkg::step_item_t            step_item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output pidc_pkg::result_item_t          result_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidc_pkg::GAIN_W-1:0]     cfg_data
);
  import pidc_pkg::*;

  cfg_t cfg;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

  logic                    op1;
  logic signed [ERR_W-1:0] e1;

  logic                    op2;
  logic signed [ERR_W-1:0] e2;
  logic signed [40:0]      p2;
  logic signed [41:0]      d2;
  logic signed [40:0]      k2;

  logic signed [SUM_W-1:0] sum3;
  logic                    clip3;
  logic signed [42:0]      pd3;

  logic signed [SUM_W-1:0] sum4;
  logic signed [60:0]      hi4;
  logic signed [60:0]      lo4;
  logic                    clip4;
  logic signed [42:0]      pd4;

  logic signed [56:0]      i5;
  logic                    clip5;
  logic signed [42:0]      pd5;

  logic signed [SUM_W-1:0] integral_sum;
  logic signed [ERR_W-1:0] previous_error;

  logic signed [56:0]      p_full;
  logic signed [32:0]      diff;
  logic signed [57:0]      d_full;
  logic signed [56:0]      k_full;
  logic signed [SUM_W-1:0] addend;
  logic signed [SUM_W:0]   sum_raw;
  logic                    sum_ovf;
  logic signed [SUM_W-1:0] sum_sat;
  logic signed [SUM_W-1:0] integral_sum_next;
  logic                    clip_sum;
  logic signed [60:0]      hi_full;
  logic signed [60:0]      lo_full;
  logic signed [72:0]      prod;
  logic signed [56:0]      i_sel;
  logic signed [57:0]      total;
  logic                    over;
  logic                    under;
  result_item_t            result_next;

  pidc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cfg_ready = 1'b1;

  assign rdy_out    = !result_valid || !result_stall;
  assign rdy5       = !v5 || rdy_out;
  assign rdy4       = !v4 || rdy5;
  assign rdy3       = !v3 || rdy4;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign step_stall = !rdy1;

  // Products of the error with the gains, and the difference for the derivative term.
  always_comb begin
    p_full = 57'(e1) * 57'($signed({1'b0, cfg.prop_gain}));
    diff   = {e1[ERR_W-1], e1} - {previous_error[ERR_W-1], previous_error};
    d_full = 58'(diff) * 58'($signed({1'b0, cfg.deriv_gain}));
    k_full = 57'(e1) * 57'($signed({1'b0, cfg.integral_recip_gain}));
  end

  // Saturating update of the integral sum, zeroed by a clear and held while disabled.
  always_comb begin
    if (cfg.scale_before_sum) begin
      addend = {{(SUM_W-41){k2[40]}}, k2};
    end else begin
      addend = {{(SUM_W-ERR_W){e2[ERR_W-1]}}, e2};
    end
    sum_raw = {integral_sum[SUM_W-1], integral_sum} + {addend[SUM_W-1], addend};
    sum_ovf = sum_raw[SUM_W] != sum_raw[SUM_W-1];
    if (sum_ovf) begin
      sum_sat = sum_raw[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_raw[SUM_W-1:0];
    end
    if (op2 == OP_CLEAR) begin
      integral_sum_next = '0;
      clip_sum          = 1'b0;
    end else if (cfg.integral_enable) begin
      integral_sum_next = sum_sat;
      clip_sum          = sum_ovf;
    end else begin
      integral_sum_next = integral_sum;
      clip_sum          = 1'b0;
    end
  end

  // The stored sum times the reciprocal gain, split into two 12-bit partial products.
  always_comb begin
    hi_full = 61'(sum3) * 61'($signed({1'b0, cfg.integral_recip_gain[23:12]}));
    lo_full = 61'(sum3) * 61'($signed({1'b0, cfg.integral_recip_gain[11:0]}));
  end

  always_comb begin
    prod = {hi4, 12'b0} + {{12{lo4[60]}}, lo4};
    if (!cfg.integral_enable) begin
      i_sel = '0;
    end else if (cfg.scale_before_sum) begin
      i_sel = {{(57-SUM_W){sum4[SUM_W-1]}}, sum4};
    end else begin
      i_sel = prod[72:16];
    end
  end

  always_comb begin
    total = {i5[56], i5} + {{15{pd5[42]}}, pd5};
    over  = !total[57] && (|total[56:31]);
    under = total[57] && !(&total[56:31]);
    if (over) begin
      result_next.control_value = OUT_MAX;
    end else if (under) begin
      result_next.control_value = OUT_MIN;
    end else begin
      result_next.control_value = total[31:0];
    end
    result_next.saturated = clip5 || over || under;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1             <= 1'b0;
      v2             <= 1'b0;
      v3             <= 1'b0;
      v4             <= 1'b0;
      v5             <= 1'b0;
      result_valid   <= 1'b0;
      integral_sum   <= '0;
      previous_error <= '0;
    end else begin
      if (rdy1) begin
        v1 <= step_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2 && (op2 == OP_STEP);
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
      if (rdy_out) begin
        result_valid <= v5;
      end
      if (v1 && rdy2) begin
        previous_error <= (op1 == OP_CLEAR) ? '0 : e1;
      end
      if (v2 && rdy3) begin
        integral_sum <= integral_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1 <= step_item.opcode;
      e1  <= step_item.error_sample;
    end
    if (rdy2) begin
      op2 <= op1;
      e2  <= e1;
      p2  <= p_full[56:16];
      d2  <= d_full[57:16];
      k2  <= k_full[56:16];
    end
    if (rdy3) begin
      sum3  <= integral_sum_next;
      clip3 <= clip_sum;
      pd3   <= {{2{p2[40]}}, p2} + {d2[41], d2};
    end
    if (rdy4) begin
      sum4  <= sum3;
      hi4   <= hi_full;
      lo4   <= lo_full;
      clip4 <= clip3;
      pd4   <= pd3;
    end
    if (rdy5) begin
      i5    <= i_sel;
      clip5 <= clip4;
      pd5   <= pd4;
    end
    if (rdy_out) begin
      result_item <= result_next;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    v1 && rdy2 && (op1 == OP_CLEAR) |=> previous_error == '0)
    else $error("previous error not cleared by a clear transaction");

  assert property (@(posedge clk) disable iff (rst)
    v2 && rdy3 && (op2 == OP_CLEAR) |=> integral_sum == '0)
    else $error("integral sum not cleared by a clear transaction");

  assert property (@(posedge clk) disable iff (rst)
    v2 && rdy3 && (op2 == OP_STEP) && !cfg.integral_enable |=> $stable(integral_sum))
    else $error("integral sum changed while the integral term is disabled");

  assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1 && $stable(e1) && $stable(op1))
    else $error("input stage lost a transaction while held");

  assert property (@(posedge clk)
    rst |=> !result_valid && !v1 && !v5)
    else $error("pipeline not empty after reset");
`endif

endmodule

// File: verif/tb_pid_controller_step.sv
// Self-checking testbench for the discrete PID controller step block.
`timescale 1ns / 1ps

module tb_pid_controller_step;
  import pidc_pkg::*;

  typedef logic signed [79:0] wide_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1850;

  class pid_step_board;
    cfg_t                    regs;
    logic signed [SUM_W-1:0] integral_sum;
    logic signed [ERR_W-1:0] last_error;
    result_item_t            pending_outputs[$];
    int                      mismatches;

    function new();
      regs = '0;
      integral_sum = '0;
      last_error = '0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [GAIN_W-1:0] val);
      case (idx)
        REG_PROP_GAIN:        regs.prop_gain = val;
        REG_INTEGRAL_RECIP:   regs.integral_recip_gain = val;
        REG_INTEGRAL_ENABLE:  regs.integral_enable = val[0];
        REG_DERIV_GAIN:       regs.deriv_gain = val;
        REG_SCALE_BEFORE_SUM: regs.scale_before_sum = val[0];
        default: ;
      endcase
    endfunction

    function void predict_step(step_item_t item);
      wide_t        e, gp, gi, gd, s, p, i_term, d, total;
      logic         clip;
      result_item_t r;
      if (item.opcode == OP_CLEAR) begin
        integral_sum = '0;
        last_error = '0;
        return;
      end
      clip = 1'b0;
      e = wide_t'(item.error_sample);
      gp = {56'd0, regs.prop_gain};
      gi = {56'd0, regs.integral_recip_gain};
      gd = {56'd0, regs.deriv_gain};
      i_term = '0;
      if (regs.integral_enable) begin
        if (regs.scale_before_sum) begin
          s = $signed(integral_sum) + ((e * gi) >>> 16);
        end else begin
          s = $signed(integral_sum) + e;
        end
        if (s > SUM_MAX) begin
          s = SUM_MAX;
          clip = 1'b1;
        end else if (s < SUM_MIN) begin
          s = SUM_MIN;
          clip = 1'b1;
        end
        integral_sum = s[SUM_W-1:0];
        i_term = regs.scale_before_sum ? s : ((s * gi) >>> 16);
      end
      p = (e * gp) >>> 16;
      d = ((e - $signed(last_error)) * gd) >>> 16;
      total = p + i_term + d;
      if (total > OUT_MAX) begin
        total = OUT_MAX;
        clip = 1'b1;
      end else if (total < OUT_MIN) begin
        total = OUT_MIN;
        clip = 1'b1;
      end
      last_error = item.error_sample;
      r.control_value = total[OUT_W-1:0];
      r.saturated = clip;
      pending_outputs.push_back(r);
    endfunction

    function void check_output(result_item_t got);
      result_item_t want;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        $error("unexpected result: control_value %0d, saturated %0b",
               $signed(got.control_value), got.saturated);
        return;
      end
      want = pending_outputs.pop_front();
      if (got.control_value !== want.control_value) begin
        mismatches++;
        $error("control_value: expected %0d, actual %0d",
               $signed(want.control_value), $signed(got.control_value));
      end
      if (got.saturated !== want.saturated) begin
        mismatches++;
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 step_valid = 1'b0;
  logic                 step_stall;
  step_item_t           step_item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_item_t         result_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data = '0;

  pid_step_board board;
  bit            calm = 1'b0;
  int            steps_sent = 0;
  int            quiet_cycles = 0;

  pid_controller_step i_dut (
    .clk          (clk),
    .rst          (rst),
    .step_valid   (step_valid),
    .step_stall   (step_stall),
    .step_item    (step_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (step_valid && !step_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** pid_controller_step: FAILED **");
      $finish;
    end
  end

  initial begin : receiver
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (rst || !(result_valid === 1'b1 && !result_stall));
      board.check_output(result_item);
    end
  end

  function automatic logic [ERR_W-1:0] rand_error();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 24'hFF_FFFF;
      2: return GAIN_W'($urandom_range(0, 24'h03_FFFF));
      default: return GAIN_W'($urandom_range(0, 24'hFF_FFFF));
    endcase
  endfunction

  task automatic send_step(logic opcode, logic [ERR_W-1:0] err);
    int         gap;
    step_item_t item;
    item.opcode = opcode;
    item.error_sample = err;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      step_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    step_valid <= 1'b1;
    step_item <= item;
    do @(posedge clk); while (step_stall !== 1'b0);
    board.predict_step(item);
    steps_sent++;
  endtask

  task automatic send_random_step();
    send_step(($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_STEP, rand_error());
  endtask

  task automatic quiesce();
    step_valid <= 1'b0;
    while (board.pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.write_reg(idx, val);
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_PROP_GAIN, c.prop_gain);
    write_reg(REG_INTEGRAL_RECIP, c.integral_recip_gain);
    write_reg(REG_INTEGRAL_ENABLE, {23'd0, c.integral_enable});
    write_reg(REG_DERIV_GAIN, c.deriv_gain);
    write_reg(REG_SCALE_BEFORE_SUM, {23'd0, c.scale_before_sum});
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t        c;
    int          phase;
    logic [27:0] low_bits;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Gains are all zero out of reset, so these give a zero output.
    send_step(OP_STEP, 32'h1234_5678);
    send_step(OP_STEP, 32'h8000_0000);
    quiesce();

    apply_config('{prop_gain: 24'h01_0000, integral_recip_gain: 24'h00_8000,
                   integral_enable: 1'b1, deriv_gain: 24'h00_4000,
                   scale_before_sum: 1'b1});
    send_step(OP_STEP, 32'h0000_0000);
    send_step(OP_STEP, 32'h0000_0001);
    send_step(OP_STEP, 32'hFFFF_FFFF);
    send_step(OP_STEP, 32'h0001_0000);
    send_step(OP_STEP, 32'h7FFF_FFFF);
    send_step(OP_STEP, 32'h8000_0000);
    send_step(OP_STEP, 32'h7FFF_FFFF);
    send_step(OP_CLEAR, 32'hDEAD_BEEF);
    send_step(OP_STEP, 32'h8000_0000);
    send_step(OP_STEP, 32'hFFFF_0000);
    send_step(OP_CLEAR, 32'h0000_0000);
    send_step(OP_STEP, 32'hFFFF_8001);
    quiesce();

    apply_config('{prop_gain: 24'hFF_FFFF, integral_recip_gain: 24'hFF_FFFF,
                   integral_enable: 1'b1, deriv_gain: 24'hFF_FFFF,
                   scale_before_sum: 1'b0});
    send_step(OP_STEP, 32'h7FFF_FFFF);
    send_step(OP_STEP, 32'h8000_0000);
    send_step(OP_STEP, 32'h7FFF_FFFF);
    send_step(OP_CLEAR, 32'hFFFF_FFFF);
    send_step(OP_STEP, 32'h0000_0001);
    send_step(OP_STEP, 32'h0000_0000);
    quiesce();

    apply_config('{prop_gain: 24'h00_0001, integral_recip_gain: 24'hFF_FFFF,
                   integral_enable: 1'b0, deriv_gain: 24'h00_0000,
                   scale_before_sum: 1'b1});
    send_step(OP_STEP, 32'h8000_0000);
    send_step(OP_STEP, 32'h0000_FFFF);
    send_step(OP_STEP, 32'hFFFF_FFFF);

    phase = 0;
    steps_sent = 0;
    while (steps_sent < RANDOM_ITEMS) begin
      quiesce();
      calm = ($urandom_range(0, 3) == 0);
      c.prop_gain = rand_gain();
      c.integral_recip_gain = rand_gain();
      c.integral_enable = 1'($urandom_range(0, 1));
      c.deriv_gain = rand_gain();
      c.scale_before_sum = 1'($urandom_range(0, 1));
      case (phase)
        0: c = '{prop_gain: '0, integral_recip_gain: '0, integral_enable: 1'b1,
                 deriv_gain: '0, scale_before_sum: 1'b1};
        1: c = '{prop_gain: 24'hFF_FFFF, integral_recip_gain: 24'hFF_FFFF,
                 integral_enable: 1'b1, deriv_gain: 24'hFF_FFFF,
                 scale_before_sum: 1'b1};
        2: begin
          c.integral_recip_gain = 24'hFF_FFFF;
          c.integral_enable = 1'b1;
          c.scale_before_sum = 1'b1;
        end
        3: c.integral_enable = 1'b0;
        default: ;
      endcase
      apply_config(c);
      if (phase == 2) begin
        // Drive the integral sum into both of its limits and hold it there.
        repeat (360) begin
          low_bits = 28'($urandom);
          if ($urandom_range(0, 9) == 0) send_random_step();
          else send_step(OP_STEP, {4'b0111, low_bits});
        end
        send_step(OP_CLEAR, rand_error());
        repeat (360) begin
          low_bits = 28'($urandom);
          if ($urandom_range(0, 9) == 0) send_random_step();
          else send_step(OP_STEP, {4'b1000, low_bits});
        end
      end else begin
        repeat ($urandom_range(60, 160)) send_random_step();
      end
      phase++;
    end

    quiesce();
    if (board.mismatches == 0) begin
      $display("** pid_controller_step: PASSED **");
    end else begin
      $display("** pid_controller_step: FAILED **");
    end
    $finish;
  end

endmodule
